FILE: rtl/core/teq_pkg.sv
package teq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;
    localparam int ID_BITS_DEF     = 16;

    // fixed port widths of the request and result beats
    localparam int PORT_TIME_W = 32;
    localparam int PORT_ID_W   = 16;
    localparam int REQ_W       = 2;
    localparam int KIND_W      = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_SCHEDULE = 2'd0,
        REQ_CANCEL   = 2'd1,
        REQ_SET_TIME = 2'd2,
        REQ_PROCESS  = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ASSIGNED = 3'd0,
        KIND_FIRED    = 3'd1,
        KIND_NONE     = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_ACK      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_SCAN,
        ST_FIRE,
        ST_RESP
    } state_t;

    // control into the best-candidate tracker
    typedef struct packed {
        logic clear;
        logic sample;
    } best_ctl_t;

    // status out of the best-candidate tracker
    typedef struct packed {
        logic found;
        logic more;
    } best_sts_t;

endpackage

FILE: rtl/core/teq_slot_mem.sv
module teq_slot_mem #(
    parameter int DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = teq_pkg::TIME_BITS_DEF + teq_pkg::ID_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/teq_best_sel.sv
module teq_best_sel #(
    parameter int IDX_W     = 4,
    parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = teq_pkg::ID_BITS_DEF
) (
    input  logic                  aclk,
    input  teq_pkg::best_ctl_t    ctl,
    input  logic [IDX_W-1:0]      cand_idx,
    input  logic [TIME_BITS-1:0]  cand_due,
    input  logic [ID_BITS-1:0]    cand_id,
    output logic [IDX_W-1:0]      best_idx,
    output logic [ID_BITS-1:0]    best_id,
    output teq_pkg::best_sts_t    sts
);

    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_due_reg;
    logic [ID_BITS-1:0]   best_id_reg;
    logic                 found_reg;
    logic                 more_reg;
    logic                 take;

    // strict compares keep the lower slot on a full tie
    assign take = !found_reg || (cand_due < best_due_reg) ||
                  ((cand_due == best_due_reg) && (cand_id < best_id_reg));

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            found_reg <= 1'b0;
            more_reg  <= 1'b0;
        end else if (ctl.sample) begin
            found_reg <= 1'b1;
            if (found_reg) begin
                more_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctl.clear && ctl.sample && take) begin
            best_idx_reg <= cand_idx;
            best_due_reg <= cand_due;
            best_id_reg  <= cand_id;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_id   = best_id_reg;
    assign sts.found = found_reg;
    assign sts.more  = more_reg;

endmodule

FILE: rtl/core/timer_event_queue.sv
// Set time goes straight to its result; schedule searches the slots for a free one,
// one valid bit per cycle; cancel makes one full pass over the slot RAM. A low m_ready holds results.
// Process: each beat follows one full pass over the slot RAM, since the read port returns
// one slot per cycle; another pass follows while a second due slot was seen in the last one.
// One request at a time; the next is taken the cycle after the final beat is loaded.
// Reset (synchronous, aresetn low) clears valid bits, current time and id counter; RAM kept.
module timer_event_queue #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS     = teq_pkg::ID_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [teq_pkg::REQ_W-1:0]       s_req_type,
    input  logic [teq_pkg::PORT_TIME_W-1:0] s_time_value,
    input  logic [teq_pkg::PORT_ID_W-1:0]   s_target_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [teq_pkg::KIND_W-1:0]      m_result_kind,
    output logic [teq_pkg::PORT_ID_W-1:0]   m_result_id,
    output logic                            m_last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int MEM_W = TIME_BITS + ID_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    teq_pkg::state_t state_reg, state_next;

    logic                   op_cancel_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   due_reg;
    logic [ID_BITS-1:0]     tgt_reg;
    logic [ID_BITS-1:0]     id_cnt_reg;
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   issue_on_reg;
    logic                   rsp_vld_reg;
    logic [IDX_W-1:0]       rsp_idx_reg;
    teq_pkg::kind_t         pend_kind_reg;
    logic [ID_BITS-1:0]     pend_id_reg;

    logic                   m_valid_reg;
    teq_pkg::kind_t         m_kind_reg;
    logic [ID_BITS-1:0]     m_id_reg;
    logic                   m_last_reg;

    logic [63:0]            tv_ext;
    logic [31:0]            tgt_ext;
    logic [31:0]            out_id_ext;
    logic [TIME_BITS-1:0]   s_tval;
    logic [ID_BITS-1:0]     s_tgt;
    teq_pkg::req_t          s_req;

    logic                   s_accept;
    logic                   out_free;
    logic                   scan_start;
    logic                   scan_done;
    logic                   rd_en;
    logic                   sched_found;
    logic                   sched_full;
    logic                   out_load;
    teq_pkg::kind_t         out_kind;
    logic [ID_BITS-1:0]     out_id;
    logic                   out_last;
    logic                   fire_clear;
    logic                   cand_valid;
    logic                   cancel_hit;
    logic                   proc_cand;
    logic [ID_BITS-1:0]     id_inc;
    logic [ID_BITS-1:0]     next_id;

    logic [MEM_W-1:0]       rd_data;
    logic [TIME_BITS-1:0]   rd_due;
    logic [ID_BITS-1:0]     rd_id;

    teq_pkg::best_ctl_t     best_ctl;
    teq_pkg::best_sts_t     best_sts;
    logic [IDX_W-1:0]       best_idx;
    logic [ID_BITS-1:0]     best_id;

    // port fields to internal widths
    assign tv_ext  = {32'd0, s_time_value};
    assign tgt_ext = {16'd0, s_target_id};
    assign s_tval  = tv_ext[TIME_BITS-1:0];
    assign s_tgt   = tgt_ext[ID_BITS-1:0];
    assign s_req   = teq_pkg::req_t'(s_req_type);

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign rd_due = rd_data[MEM_W-1:ID_BITS];
    assign rd_id  = rd_data[ID_BITS-1:0];

    assign scan_done  = rsp_vld_reg && (rsp_idx_reg == LAST_IDX);
    assign cand_valid = rsp_vld_reg && valid_reg[rsp_idx_reg];
    assign cancel_hit = cand_valid && op_cancel_reg && (rd_id == tgt_reg);
    assign proc_cand  = cand_valid && !op_cancel_reg && (rd_due <= now_reg);

    // ids count 1..max and skip zero on wrap
    assign id_inc  = id_cnt_reg + ID_BITS'(1);
    assign next_id = (id_inc == '0) ? ID_BITS'(1) : id_inc;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            teq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_req)
                        teq_pkg::REQ_SCHEDULE: state_next = teq_pkg::ST_SCHED;
                        teq_pkg::REQ_CANCEL:   state_next = teq_pkg::ST_SCAN;
                        teq_pkg::REQ_SET_TIME: state_next = teq_pkg::ST_RESP;
                        teq_pkg::REQ_PROCESS:  state_next = teq_pkg::ST_SCAN;
                    endcase
                end
            end
            teq_pkg::ST_SCHED: begin
                if (!valid_reg[idx_reg] || (idx_reg == LAST_IDX)) begin
                    state_next = teq_pkg::ST_RESP;
                end
            end
            teq_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = op_cancel_reg ? teq_pkg::ST_RESP : teq_pkg::ST_FIRE;
                end
            end
            teq_pkg::ST_FIRE: begin
                if (out_free) begin
                    state_next = (best_sts.found && best_sts.more) ?
                                 teq_pkg::ST_SCAN : teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            default: state_next = teq_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = 1'b0;
        scan_start  = 1'b0;
        rd_en       = 1'b0;
        sched_found = 1'b0;
        sched_full  = 1'b0;
        out_load    = 1'b0;
        out_kind    = teq_pkg::KIND_NONE;
        out_id      = '0;
        out_last    = 1'b1;
        fire_clear  = 1'b0;
        unique case (state_reg)
            teq_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                scan_start = s_valid && ((s_req == teq_pkg::REQ_CANCEL) ||
                                         (s_req == teq_pkg::REQ_PROCESS));
            end
            teq_pkg::ST_SCHED: begin
                sched_found = !valid_reg[idx_reg];
                sched_full  = valid_reg[idx_reg] && (idx_reg == LAST_IDX);
            end
            teq_pkg::ST_SCAN: begin
                rd_en = issue_on_reg;
            end
            teq_pkg::ST_FIRE: begin
                out_load   = out_free;
                out_kind   = best_sts.found ? teq_pkg::KIND_FIRED : teq_pkg::KIND_NONE;
                out_id     = best_sts.found ? best_id : '0;
                out_last   = !(best_sts.found && best_sts.more);
                fire_clear = out_free && best_sts.found;
                scan_start = out_free && best_sts.found && best_sts.more;
            end
            teq_pkg::ST_RESP: begin
                out_load = out_free;
                out_kind = pend_kind_reg;
                out_id   = pend_id_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= teq_pkg::ST_IDLE;
            valid_reg    <= '0;
            issue_on_reg <= 1'b0;
            rsp_vld_reg  <= 1'b0;
            now_reg      <= '0;
            id_cnt_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rsp_vld_reg <= rd_en;

            if (scan_start) begin
                issue_on_reg <= 1'b1;
            end else if (rd_en && (idx_reg == LAST_IDX)) begin
                issue_on_reg <= 1'b0;
            end

            if (sched_found) begin
                valid_reg[idx_reg] <= 1'b1;
                id_cnt_reg         <= next_id;
            end
            if (cancel_hit) begin
                valid_reg[rsp_idx_reg] <= 1'b0;
            end
            if (fire_clear) begin
                valid_reg[best_idx] <= 1'b0;
            end

            if (s_accept && (s_req == teq_pkg::REQ_SET_TIME)) begin
                now_reg <= s_tval;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rsp_idx_reg <= idx_reg;

        if (s_accept || scan_start) begin
            idx_reg <= '0;
        end else if (rd_en || (state_reg == teq_pkg::ST_SCHED && !sched_found && !sched_full)) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end

        if (s_accept) begin
            due_reg       <= s_tval;
            tgt_reg       <= s_tgt;
            op_cancel_reg <= (s_req == teq_pkg::REQ_CANCEL);
        end

        if (sched_found) begin
            pend_kind_reg <= teq_pkg::KIND_ASSIGNED;
            pend_id_reg   <= next_id;
        end else if (sched_full) begin
            pend_kind_reg <= teq_pkg::KIND_FULL;
            pend_id_reg   <= '0;
        end else if ((s_accept && (s_req == teq_pkg::REQ_SET_TIME)) ||
                     (state_reg == teq_pkg::ST_SCAN && scan_done && op_cancel_reg)) begin
            pend_kind_reg <= teq_pkg::KIND_ACK;
            pend_id_reg   <= '0;
        end

        if (out_load) begin
            m_kind_reg <= out_kind;
            m_id_reg   <= out_id;
            m_last_reg <= out_last;
        end
    end

    teq_slot_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (MEM_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (sched_found),
        .wr_addr (idx_reg),
        .wr_data ({due_reg, next_id}),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign best_ctl.clear  = scan_start;
    assign best_ctl.sample = proc_cand;

    teq_best_sel #(
        .IDX_W     (IDX_W),
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
    ) u_best_sel (
        .aclk     (aclk),
        .ctl      (best_ctl),
        .cand_idx (rsp_idx_reg),
        .cand_due (rd_due),
        .cand_id  (rd_id),
        .best_idx (best_idx),
        .best_id  (best_id),
        .sts      (best_sts)
    );

    assign out_id_ext    = 32'(m_id_reg);
    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_result_id   = out_id_ext[teq_pkg::PORT_ID_W-1:0];
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // a new beat never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");

    // a finished process pass always goes on to emit
    a_scan_to_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == teq_pkg::ST_SCAN && scan_done && !op_cancel_reg)
        |=> (state_reg == teq_pkg::ST_FIRE))
        else $error("process pass did not reach emit");

    // only a fired beat may be followed by more beats of the same request
    a_nonlast_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_kind_reg == teq_pkg::KIND_FIRED))
        else $error("non-final beat of wrong kind");

    // the tracker never reports a second candidate without a first
    a_more_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == teq_pkg::ST_FIRE && best_sts.more) |-> best_sts.found)
        else $error("tracker status inconsistent");
`endif

endmodule
